// ===== rtl/core/srle_pkg.sv =====
// Shared types and constants of the sprite RLE byte decoder.
package srle_pkg;

    localparam logic [7:0] RUN_FLAG     = 8'h80;
    localparam logic [6:0] COUNT_MASK   = 7'h7F;
    localparam logic [2:0] HEADER_BYTES = 3'd4;
    localparam int         BYTE_BITS    = 8;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_RUN    = 2'd1,
        KIND_FILL   = 2'd2,
        KIND_SHORT  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_HEADER = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_SHORT  = 2'd3
    } t_op;

    // One classified byte, handed from front end to back end.
    typedef struct packed {
        t_op         op;
        logic [7:0]  value;
        logic [6:0]  count;
        logic        record_end;
        logic [15:0] width;
        logic [15:0] height;
    } t_cmd;

endpackage

// ===== rtl/core/srle_if.sv =====
// Valid/ready stream interfaces for the decoder's byte input and result output.
interface srle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       record_end;

    modport source (output valid, output data_byte, output record_end, input ready);
    modport sink   (input valid, input data_byte, input record_end, output ready);
endinterface

interface srle_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pixel_value;
    logic [31:0] run_length;
    logic [31:0] start_index;
    logic [15:0] width;
    logic [15:0] height;
    logic        record_last;

    modport source (output valid, output kind, output pixel_value, output run_length,
                    output start_index, output width, output height,
                    output record_last, input ready);
    modport sink   (input valid, input kind, input pixel_value, input run_length,
                    input start_index, input width, input height,
                    input record_last, output ready);
endinterface

// ===== rtl/core/srle_fifo.sv =====
// Small synchronous command queue between front end and back end.
module srle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            priority if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end else begin
                r_count <= r_count;
            end
        end
    end
endmodule

// ===== rtl/core/srle_front.sv =====
// Front end: accepts bytes, parses the header and classifies literal and run bytes.
module srle_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srle_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output srle_pkg::t_cmd  o_cmd
);
    import srle_pkg::*;

    logic [2:0]  r_hpos,  n_hpos;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic        r_pend,  n_pend;
    logic [6:0]  r_cnt,   n_cnt;
    logic        accept;
    logic [7:0]  b;
    logic        rec_end;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign rec_end    = i_in.record_end;

    always_comb begin
        n_hpos   = r_hpos;
        n_width  = r_width;
        n_height = r_height;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        o_cmd    = '{op: OP_NONE, value: b, count: 7'd1, record_end: rec_end,
                     width: r_width, height: r_height};

        if (r_hpos < HEADER_BYTES) begin
            unique case (r_hpos[1:0])
                2'd0: n_width  = {8'h00, b};
                2'd1: n_width  = {b, r_width[BYTE_BITS-1:0]};
                2'd2: n_height = {8'h00, b};
                2'd3: n_height = {b, r_height[BYTE_BITS-1:0]};
                default: n_width = r_width;
            endcase
            n_hpos       = r_hpos + 3'd1;
            o_cmd.width  = n_width;
            o_cmd.height = n_height;
            if (n_hpos == HEADER_BYTES) begin
                o_cmd.op = OP_HEADER;
            end else if (rec_end) begin
                // short record carries its own last flag, no fill follows
                o_cmd.op         = OP_SHORT;
                o_cmd.record_end = 1'b0;
            end
        end else if (r_pend) begin
            n_pend      = 1'b0;
            o_cmd.op    = OP_PIXEL;
            o_cmd.count = r_cnt;
        end else if ((b & RUN_FLAG) != 8'h00) begin
            n_pend = 1'b1;
            n_cnt  = b[6:0] & COUNT_MASK;
        end else begin
            o_cmd.op = OP_PIXEL;
        end

        if (rec_end) begin
            n_hpos   = '0;
            n_width  = '0;
            n_height = '0;
            n_pend   = 1'b0;
            n_cnt    = '0;
        end
    end

    // skip bytes with no result: run prefixes, header bytes 0-2; not at record end
    assign o_push = accept && ((o_cmd.op != OP_NONE) || rec_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpos   <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_pend   <= 1'b0;
            r_cnt    <= '0;
        end else if (accept) begin
            r_hpos   <= n_hpos;
            r_width  <= n_width;
            r_height <= n_height;
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
        end
    end
endmodule

// ===== rtl/core/srle_back.sv =====
// Back end: clips runs to the pixel total, tracks position and emits result beats.
module srle_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  srle_pkg::t_cmd  i_cmd,
    input  logic            i_empty,
    output logic            o_pop,
    srle_out_if.source      o_out
);
    import srle_pkg::*;

    logic [15:0] r_width,   n_width;
    logic [15:0] r_height,  n_height;
    logic [31:0] r_total,   n_total;
    logic [31:0] r_written, n_written;
    logic        r_phase,   n_phase;
    logic        r_ov,      n_ov;

    t_kind       r_kind,    n_kind;
    logic [7:0]  r_value,   n_value;
    logic [31:0] r_len,     n_len;
    logic [31:0] r_start,   n_start;
    logic [15:0] r_ow,      n_ow;
    logic [15:0] r_oh,      n_oh;
    logic        r_last,    n_last;

    logic        can_load;
    logic        load;
    logic [31:0] remaining;
    logic [31:0] cnt32;
    logic [31:0] clip_len;
    logic        first_valid;

    assign can_load  = !r_ov || o_out.ready;
    assign remaining = r_total - r_written;
    assign cnt32     = {25'd0, i_cmd.count};
    assign clip_len  = (cnt32 < remaining) ? cnt32 : remaining;

    always_comb begin
        unique case (i_cmd.op)
            OP_HEADER: first_valid = 1'b1;
            OP_SHORT:  first_valid = 1'b1;
            OP_PIXEL:  first_valid = (clip_len != 32'd0);
            default:   first_valid = 1'b0;
        endcase
    end

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_total   = r_total;
        n_written = r_written;
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_value   = r_value;
        n_len     = r_len;
        n_start   = r_start;
        n_ow      = r_ow;
        n_oh      = r_oh;
        n_last    = r_last;
        load      = 1'b0;
        o_pop     = 1'b0;

        if (!i_empty && can_load) begin
            if (!r_phase && first_valid) begin
                load    = 1'b1;
                n_value = 8'h00;
                n_len   = 32'd0;
                n_start = 32'd0;
                n_last  = 1'b0;
                unique case (i_cmd.op)
                    OP_HEADER: begin
                        n_kind    = KIND_HEADER;
                        n_ow      = i_cmd.width;
                        n_oh      = i_cmd.height;
                        n_width   = i_cmd.width;
                        n_height  = i_cmd.height;
                        n_total   = 32'(i_cmd.width) * 32'(i_cmd.height);
                        n_written = 32'd0;
                    end
                    OP_SHORT: begin
                        n_kind    = KIND_SHORT;
                        n_ow      = 16'd0;
                        n_oh      = 16'd0;
                        n_last    = 1'b1;
                        n_width   = '0;
                        n_height  = '0;
                        n_total   = '0;
                        n_written = '0;
                    end
                    default: begin
                        n_kind    = KIND_RUN;
                        n_value   = i_cmd.value;
                        n_len     = clip_len;
                        n_start   = r_written;
                        n_ow      = r_width;
                        n_oh      = r_height;
                        n_written = r_written + clip_len;
                    end
                endcase
                // hold the command for its fill beat
                if (i_cmd.record_end) begin
                    n_phase = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                o_pop   = 1'b1;
                n_phase = 1'b0;
                if (i_cmd.record_end) begin
                    load      = 1'b1;
                    n_kind    = KIND_FILL;
                    n_value   = 8'h00;
                    n_len     = remaining;
                    n_start   = r_written;
                    n_ow      = r_width;
                    n_oh      = r_height;
                    n_last    = 1'b1;
                    n_width   = '0;
                    n_height  = '0;
                    n_total   = '0;
                    n_written = '0;
                end
            end
        end

        priority if (load) begin
            n_ov = 1'b1;
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= '0;
            r_height  <= '0;
            r_total   <= '0;
            r_written <= '0;
            r_phase   <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_total   <= n_total;
            r_written <= n_written;
            r_phase   <= n_phase;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_value <= n_value;
        r_len   <= n_len;
        r_start <= n_start;
        r_ow    <= n_ow;
        r_oh    <= n_oh;
        r_last  <= n_last;
    end

    assign o_out.valid       = r_ov;
    assign o_out.kind        = r_kind;
    assign o_out.pixel_value = r_value;
    assign o_out.run_length  = r_len;
    assign o_out.start_index = r_start;
    assign o_out.width       = r_ow;
    assign o_out.height      = r_oh;
    assign o_out.record_last = r_last;
endmodule

// ===== rtl/core/sprite_rle_byte_decoder_core.sv =====
// Top level of the sprite RLE byte decoder: front end, command queue, back end.
//
//  channel  | dir | beat                          | accepted when
//  ---------+-----+-------------------------------+--------------------------
//  i_in     | in  | data_byte, record_end         | i_in.valid && i_in.ready
//  o_out    | out | kind, pixel_value, run_length,| o_out.valid && o_out.ready
//           |     | start_index, width, height,   |
//           |     | record_last                   |
//
// The front end takes one byte per cycle while the command queue has room.
// The back end issues one result beat per cycle from its output register while
// o_out is ready; a byte that ends a record after a literal, a run or the header
// gives two beats, its own and a fill, which the QUEUE_DEPTH-entry queue absorbs.
// Synchronous active-low reset clears all record state and the queue.
// A stall on o_out fills the queue and then drops i_in.ready.
module sprite_rle_byte_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srle_in_if.sink    i_in,
    srle_out_if.source o_out
);
    import srle_pkg::*;

    t_cmd front_cmd;
    t_cmd back_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    srle_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    srle_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (back_cmd),
        .o_empty (empty)
    );

    srle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (back_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule
